/* design/tmse_pkg.sv */
// tmse_pkg: shared constants, codes, types and helper functions
// for the turing machine step engine; depends on nothing
`default_nettype none

package tmse_pkg;

    // sizes
    localparam int NUM_STATES  = 64;
    localparam int TAPE_LEN    = 1024;
    localparam int SYMBOL_BITS = 8;

    localparam int MODE_W   = 3;
    localparam int STATE_W  = 6;
    localparam int DIR_W    = 2;
    localparam int POS_W    = 10;
    localparam int STATUS_W = 2;

    localparam int RULE_DEPTH = NUM_STATES * (2 ** SYMBOL_BITS);
    localparam int RULE_AW    = $clog2(RULE_DEPTH);
    localparam int TAPE_AW    = $clog2(TAPE_LEN);
    localparam int HALF_LEN   = TAPE_LEN / 2;
    localparam int CLR_DEPTH  = (RULE_DEPTH > TAPE_LEN) ? RULE_DEPTH : TAPE_LEN;
    localparam int CLR_W      = $clog2(CLR_DEPTH);

    // symbols
    localparam logic [SYMBOL_BITS-1:0] SYM_WILD  = SYMBOL_BITS'(42);
    localparam logic [SYMBOL_BITS-1:0] SYM_BLANK = SYMBOL_BITS'(95);
    localparam logic [SYMBOL_BITS-1:0] SYM_SPACE = SYMBOL_BITS'(32);

    // item modes
    localparam logic [MODE_W-1:0] MODE_LOAD_RULE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_CELL = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MARK_HALT = 3'd2;
    localparam logic [MODE_W-1:0] MODE_START     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_STEP      = 3'd4;
    localparam logic [MODE_W-1:0] MODE_READ_CELL = 3'd5;

    // head moves
    localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd0;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd1;

    // run status
    localparam logic [STATUS_W-1:0] ST_RUN    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_HALT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NORULE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_LIMIT  = 2'd3;

    typedef struct packed {
        logic                   valid;
        logic [SYMBOL_BITS-1:0] wsym;
        logic [DIR_W-1:0]       dir;
        logic [STATE_W-1:0]     nxt;
    } rule_ent_t;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic [STATE_W-1:0]       state_index;
        logic [SYMBOL_BITS-1:0]   match_sym;
        logic [SYMBOL_BITS-1:0]   put_sym;
        logic [DIR_W-1:0]         direction;
        logic [STATE_W-1:0]       goto_state;
        logic signed [POS_W-1:0]  position;
        logic [SYMBOL_BITS-1:0]   symbol;
    } item_t;

    typedef struct packed {
        logic                     load;
        logic [STATUS_W-1:0]      status;
        logic [STATE_W-1:0]       current_state_out;
        logic signed [POS_W-1:0]  head_position;
        logic [SYMBOL_BITS-1:0]   head_sym;
        logic [SYMBOL_BITS-1:0]   cell_symbol;
    } result_t;

    typedef struct packed {
        logic               we;
        logic [RULE_AW-1:0] addr;
        rule_ent_t          data;
    } rule_wr_t;

    typedef struct packed {
        logic                   we;
        logic [TAPE_AW-1:0]     addr;
        logic [SYMBOL_BITS-1:0] data;
    } tape_wr_t;

    // position on the tape, one bit wider than the port so a move can leave it
    function automatic logic pos_ok(input logic signed [POS_W:0] p);
        int v;
        v = int'(p);
        return (v >= -HALF_LEN) && (v < TAPE_LEN - HALF_LEN);
    endfunction

    function automatic logic [TAPE_AW-1:0] tape_idx(input logic signed [POS_W:0] p);
        int v;
        v = int'(p) + HALF_LEN;
        return TAPE_AW'(v);
    endfunction

    function automatic logic state_ok(input logic [STATE_W-1:0] s);
        return int'(s) < NUM_STATES;
    endfunction

    function automatic logic [RULE_AW-1:0] rule_addr(input logic [STATE_W-1:0] s,
                                                     input logic [SYMBOL_BITS-1:0] sym);
        return RULE_AW'({s, sym});
    endfunction

endpackage

`default_nettype wire

/* design/tmse_rule_ram.sv */
// tmse_rule_ram: rule store, one write port and two registered read ports
// depends on tmse_pkg for sizes and the rule entry type
`default_nettype none

module tmse_rule_ram (
    input  wire logic                        clk,
    input  wire tmse_pkg::rule_wr_t          wr,
    input  wire logic [tmse_pkg::RULE_AW-1:0] rd_addr_a,
    input  wire logic [tmse_pkg::RULE_AW-1:0] rd_addr_b,
    output tmse_pkg::rule_ent_t              rd_data_a,
    output tmse_pkg::rule_ent_t              rd_data_b
);
    import tmse_pkg::*;

    rule_ent_t mem [RULE_DEPTH];
    rule_ent_t rd_a_reg;
    rule_ent_t rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_a_reg <= mem[rd_addr_a];
        rd_b_reg <= mem[rd_addr_b];
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

`default_nettype wire

/* design/tmse_tape_ram.sv */
// tmse_tape_ram: tape cell store, one write port and one registered read port
// depends on tmse_pkg for sizes and the write request type
`default_nettype none

module tmse_tape_ram (
    input  wire logic                            clk,
    input  wire tmse_pkg::tape_wr_t              wr,
    input  wire logic [tmse_pkg::TAPE_AW-1:0]    rd_addr,
    output logic [tmse_pkg::SYMBOL_BITS-1:0]     rd_data
);
    import tmse_pkg::*;

    logic [SYMBOL_BITS-1:0] mem [TAPE_LEN];
    logic [SYMBOL_BITS-1:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_reg <= mem[rd_addr];
    end

    assign rd_data = rd_reg;

endmodule

`default_nettype wire

/* design/tmse_seq.sv */
// tmse_seq: item sequencer with machine registers, halt marks and clearing pass
// depends on tmse_pkg; drives tmse_rule_ram and tmse_tape_ram
`default_nettype none

module tmse_seq (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_fire,
    input  wire tmse_pkg::item_t                    item,
    output logic                                    in_ready,
    input  wire logic                               cfg_we,
    input  wire logic [tmse_pkg::STATE_W-1:0]       cfg_wdata,
    input  wire logic                               slot_free,
    output tmse_pkg::result_t                       res,
    output logic [tmse_pkg::RULE_AW-1:0]            rule_rd_exact,
    output logic [tmse_pkg::RULE_AW-1:0]            rule_rd_fallback,
    input  wire tmse_pkg::rule_ent_t                rule_q_exact,
    input  wire tmse_pkg::rule_ent_t                rule_q_fallback,
    output tmse_pkg::rule_wr_t                      rule_wr,
    output logic [tmse_pkg::TAPE_AW-1:0]            tape_rd_addr,
    input  wire logic [tmse_pkg::SYMBOL_BITS-1:0]   tape_q,
    output tmse_pkg::tape_wr_t                      tape_wr
);
    import tmse_pkg::*;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_EX   = 3'd2;
    localparam logic [2:0] S_HS   = 3'd3;
    localparam logic [2:0] S_WB   = 3'd4;

    localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(CLR_DEPTH - 1);

    logic [2:0]               st_reg, st_next;
    logic [CLR_W-1:0]         clr_cnt_reg, clr_cnt_next;
    item_t                    req_reg;
    logic [STATE_W-1:0]       state_reg, state_next;
    logic signed [POS_W-1:0]  head_reg, head_next;
    logic [STATUS_W-1:0]      status_reg, status_next;
    logic [SYMBOL_BITS-1:0]   head_sym_reg, head_sym_next;
    logic [SYMBOL_BITS-1:0]   cell_reg, cell_next;
    logic [STATE_W-1:0]       init_reg;
    logic [NUM_STATES-1:0]    halt_reg, halt_next;

    rule_ent_t                ent;
    logic                     ent_ok;
    logic signed [POS_W:0]    head_ext;
    logic signed [POS_W:0]    req_pos_ext;
    logic signed [POS_W:0]    np;
    logic                     np_ok;
    logic signed [POS_W:0]    acc_pos;
    logic [SYMBOL_BITS-1:0]   load_sym;

    // fallback sits in the same table at the wildcard slot, written by a rule load whose match symbol is the wildcard
    assign ent = rule_q_exact.valid ? rule_q_exact : rule_q_fallback;
    assign ent_ok = state_ok(state_reg) && ent.valid;

    assign head_ext    = {head_reg[POS_W-1], head_reg};
    assign req_pos_ext = {req_reg.position[POS_W-1], req_reg.position};

    always_comb
    begin
        case (ent.dir)
            DIR_LEFT:  np = head_ext - (POS_W+1)'(1);
            DIR_RIGHT: np = head_ext + (POS_W+1)'(1);
            default:   np = head_ext;
        endcase
    end
    assign np_ok = pos_ok(np);

    assign load_sym = (req_reg.symbol == SYM_SPACE) ? SYM_BLANK : req_reg.symbol;

    assign in_ready = (st_reg == S_IDLE) || ((st_reg == S_WB) && slot_free);

    // reads for the next item go out in the cycle it is taken
    assign rule_rd_exact    = rule_addr(state_reg, head_sym_reg);
    assign rule_rd_fallback = rule_addr(state_reg, SYM_WILD);
    assign acc_pos = (item.mode == MODE_START) ? '0 : {item.position[POS_W-1], item.position};
    assign tape_rd_addr = (st_reg == S_EX) ? tape_idx(np) : tape_idx(acc_pos);

    always_comb
    begin
        st_next       = st_reg;
        clr_cnt_next  = clr_cnt_reg;
        state_next    = state_reg;
        head_next     = head_reg;
        status_next   = status_reg;
        head_sym_next = head_sym_reg;
        cell_next     = cell_reg;
        halt_next     = halt_reg;
        rule_wr       = '0;
        tape_wr       = '0;
        res           = '0;

        case (st_reg)
            S_CLR:
            begin
                rule_wr.we   = 1'b1;
                rule_wr.addr = clr_cnt_reg[RULE_AW-1:0];
                tape_wr.we   = 1'b1;
                tape_wr.addr = clr_cnt_reg[TAPE_AW-1:0];
                tape_wr.data = SYM_BLANK;
                clr_cnt_next = clr_cnt_reg + CLR_W'(1);
                if (clr_cnt_reg == CLR_LAST)
                begin
                    st_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    st_next = S_EX;
                end
            end
            S_EX:
            begin
                st_next   = S_WB;
                cell_next = '0;
                case (req_reg.mode)
                    MODE_LOAD_RULE:
                    begin
                        if (state_ok(req_reg.state_index))
                        begin
                            rule_wr.we        = 1'b1;
                            rule_wr.addr      = rule_addr(req_reg.state_index,
                                                          req_reg.match_sym);
                            rule_wr.data.valid = 1'b1;
                            rule_wr.data.wsym = req_reg.put_sym;
                            rule_wr.data.dir  = req_reg.direction;
                            rule_wr.data.nxt  = req_reg.goto_state;
                        end
                    end
                    MODE_LOAD_CELL:
                    begin
                        if (pos_ok(req_pos_ext))
                        begin
                            tape_wr.we   = 1'b1;
                            tape_wr.addr = tape_idx(req_pos_ext);
                            tape_wr.data = load_sym;
                            if (req_reg.position == head_reg)
                            begin
                                head_sym_next = load_sym;
                            end
                        end
                    end
                    MODE_MARK_HALT:
                    begin
                        if (state_ok(req_reg.state_index))
                        begin
                            halt_next[req_reg.state_index] = 1'b1;
                        end
                    end
                    MODE_START:
                    begin
                        state_next    = init_reg;
                        head_next     = '0;
                        status_next   = ST_RUN;
                        head_sym_next = tape_q;
                    end
                    MODE_STEP:
                    begin
                        if (status_reg == ST_RUN)
                        begin
                            if (!ent_ok)
                            begin
                                status_next = ST_NORULE;
                            end
                            else if (!np_ok)
                            begin
                                status_next = ST_LIMIT;
                            end
                            else
                            begin
                                if (ent.wsym != SYM_WILD)
                                begin
                                    tape_wr.we   = 1'b1;
                                    tape_wr.addr = tape_idx(head_ext);
                                    tape_wr.data = ent.wsym;
                                end
                                head_next  = np[POS_W-1:0];
                                state_next = ent.nxt;
                                if (state_ok(ent.nxt) && halt_reg[ent.nxt])
                                begin
                                    status_next = ST_HALT;
                                end
                                if (ent.dir == DIR_LEFT || ent.dir == DIR_RIGHT)
                                begin
                                    // new cell comes back from the read issued here
                                    st_next = S_HS;
                                end
                                else if (ent.wsym != SYM_WILD)
                                begin
                                    head_sym_next = ent.wsym;
                                end
                            end
                        end
                    end
                    MODE_READ_CELL:
                    begin
                        cell_next = pos_ok(req_pos_ext) ? tape_q : SYM_BLANK;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_HS:
            begin
                head_sym_next = tape_q;
                st_next       = S_WB;
            end
            S_WB:
            begin
                if (slot_free)
                begin
                    res.load              = 1'b1;
                    res.status            = status_reg;
                    res.current_state_out = state_reg;
                    res.head_position     = head_reg;
                    res.head_sym          = head_sym_reg;
                    res.cell_symbol       = cell_reg;
                    st_next               = in_fire ? S_EX : S_IDLE;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= S_CLR;
            clr_cnt_reg  <= '0;
            state_reg    <= '0;
            head_reg     <= '0;
            status_reg   <= ST_RUN;
            head_sym_reg <= SYM_BLANK;
            init_reg     <= '0;
            halt_reg     <= '0;
        end
        else
        begin
            st_reg       <= st_next;
            clr_cnt_reg  <= clr_cnt_next;
            state_reg    <= state_next;
            head_reg     <= head_next;
            status_reg   <= status_next;
            head_sym_reg <= head_sym_next;
            halt_reg     <= halt_next;
            if (cfg_we)
            begin
                init_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
        if (in_fire)
        begin
            req_reg <= item;
        end
    end

    // machine registers only move while an item executes
    assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != S_EX && st_reg != S_HS) |=>
            ($stable(status_reg) && $stable(state_reg) && $stable(head_reg)))
        else $error("machine state changed outside execution");

    // a stopped machine ignores steps
    assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_EX && req_reg.mode == MODE_STEP && status_reg != ST_RUN) |=>
            ($stable(status_reg) && $stable(state_reg) && $stable(head_reg)))
        else $error("step ran on a stopped machine");

    // moving step reads the new cell at an address other than the one written
    assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_EX && tape_wr.we && req_reg.mode == MODE_STEP && st_next == S_HS)
            |-> (tape_wr.addr != tape_rd_addr))
        else $error("tape read and write collide on a move");

    // clearing pass covers every entry before items are taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_CLR && st_next != S_CLR) |-> (clr_cnt_reg == CLR_LAST))
        else $error("clearing pass ended early");

    // a result is only pushed into a free output slot
    assert property (@(posedge clk) disable iff (!rst_n)
        res.load |-> (slot_free && st_reg == S_WB))
        else $error("result loaded into a busy output");

endmodule

`default_nettype wire

/* design/turing_machine_step_engine_core.sv */
// turing_machine_step_engine_core: top level of the single-tape turing machine engine
// depends on tmse_pkg, tmse_rule_ram, tmse_tape_ram and tmse_seq
//
// channel     dir  handshake                      contents
// s_axis      in   s_axis_tvalid / s_axis_tready  tuser: mode; tdata: item fields
// m_axis      out  m_axis_tvalid / m_axis_tready  tdata: result fields
// cfg         in   cfg_we                         cfg_wdata: initial_state
//
// every item gives one result transfer; rule and tape reads are registered at the input
// transfer edge, an execute state follows, then a result state loads the output register;
// a step that moves the head passes an extra state between them that reads the cell under
// the moved head; the next input is taken as a result loads, so items do not overlap
// after reset a clearing pass sweeps the rule memory (all invalid) and the
// tape (all blank), and no input transfer is taken until it is done; cfg writes go in anytime
// a stalled output holds the engine in its result phase; the next input transfer is taken
// in the same cycle the waiting result leaves the output register
`default_nettype none

module turing_machine_step_engine_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // item in
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // state_index[5:0], match_sym[13:6], put_sym[21:14], direction[23:22],
    // goto_state[29:24], position[39:30], symbol[47:40]
    input  wire logic [47:0] s_axis_tdata,
    // mode[2:0]
    input  wire logic [2:0]  s_axis_tuser,
    // result out
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // status[1:0], current_state_out[7:2], head_position[17:8], head_sym[25:18],
    // cell_symbol[33:26], zero fill [39:34]
    output logic [39:0]      m_axis_tdata,
    // initial_state register
    input  wire logic        cfg_we,
    input  wire logic [5:0]  cfg_wdata
);
    import tmse_pkg::*;

    item_t                   item;
    logic                    in_fire;
    logic                    slot_free;
    result_t                 res;

    logic [RULE_AW-1:0]      rule_rd_exact;
    logic [RULE_AW-1:0]      rule_rd_fallback;
    rule_ent_t               rule_q_exact;
    rule_ent_t               rule_q_fallback;
    rule_wr_t                rule_wr;
    logic [TAPE_AW-1:0]      tape_rd_addr;
    logic [SYMBOL_BITS-1:0]  tape_q;
    tape_wr_t                tape_wr;

    logic                    out_valid_reg;
    logic [39:0]             out_data_reg;

    // unpack the input transfer
    assign item.mode         = s_axis_tuser;
    assign item.state_index  = s_axis_tdata[5:0];
    assign item.match_sym    = s_axis_tdata[13:6];
    assign item.put_sym      = s_axis_tdata[21:14];
    assign item.direction    = s_axis_tdata[23:22];
    assign item.goto_state   = s_axis_tdata[29:24];
    assign item.position     = s_axis_tdata[39:30];
    assign item.symbol       = s_axis_tdata[47:40];

    assign in_fire   = s_axis_tvalid && s_axis_tready;
    // output register is free now or empties at this edge
    assign slot_free = !out_valid_reg || m_axis_tready;

    tmse_rule_ram u_rule_ram (
        .clk       (clk),
        .wr        (rule_wr),
        .rd_addr_a (rule_rd_exact),
        .rd_addr_b (rule_rd_fallback),
        .rd_data_a (rule_q_exact),
        .rd_data_b (rule_q_fallback)
    );

    tmse_tape_ram u_tape_ram (
        .clk     (clk),
        .wr      (tape_wr),
        .rd_addr (tape_rd_addr),
        .rd_data (tape_q)
    );

    tmse_seq u_seq (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_fire          (in_fire),
        .item             (item),
        .in_ready         (s_axis_tready),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .slot_free        (slot_free),
        .res              (res),
        .rule_rd_exact    (rule_rd_exact),
        .rule_rd_fallback (rule_rd_fallback),
        .rule_q_exact     (rule_q_exact),
        .rule_q_fallback  (rule_q_fallback),
        .rule_wr          (rule_wr),
        .tape_rd_addr     (tape_rd_addr),
        .tape_q           (tape_q),
        .tape_wr          (tape_wr)
    );

    // output register: holds one finished result until its transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.load)
        begin
            out_data_reg <= {6'd0, res.cell_symbol, res.head_sym, res.head_position,
                             res.current_state_out, res.status};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire
